>>> hdl/backlight_linear_fade_unit_assert.svh
// Assertion macros shared by the backlight fade unit modules.
// Each use stands on a line of its own; clock and reset are passed in.
`ifndef BACKLIGHT_LINEAR_FADE_UNIT_ASSERT_SVH
`define BACKLIGHT_LINEAR_FADE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BLF_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("blf assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define BLF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("blf assertion failed");

`endif

>>> hdl/blf_pkg.sv
// ============================================================================
// blf_pkg
// Shared types and constants of the backlight linear fade unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package blf_pkg;

    localparam int OP_W     = 2;
    localparam int LEVEL_W  = 8;
    localparam int DUR_W    = 16;
    localparam int PROD_W   = LEVEL_W + DUR_W;   // product and dividend width
    localparam int DIV_STEPS = LEVEL_W;          // one quotient bit per step
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [OP_W-1:0] {
        OP_SET    = 2'd0,
        OP_FADE   = 2'd1,
        OP_SWITCH = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // apply the accepted item to the state
        logic mul;        // form the two interpolation products
        logic sum;        // combine products, load the divider
        logic div_step;   // one restoring division step
        logic apply;      // write the quotient as applied duty
        logic push;       // load the result register
    } blf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;   // accepted tick lands inside a running fade
    } blf_status_t;

endpackage

`default_nettype wire

>>> hdl/blf_datapath.sv
// ============================================================================
// blf_datapath
// Fade state, interpolation multipliers, serial divider and result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "backlight_linear_fade_unit_assert.svh"

module blf_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [blf_pkg::OP_W-1:0]      s_op,
    input  wire logic [blf_pkg::LEVEL_W-1:0]   s_level,
    input  wire logic [blf_pkg::DUR_W-1:0]     s_duration_ms,
    input  wire logic                          s_backlight_on,
    input  wire blf_pkg::blf_cmd_t             cmd,
    output blf_pkg::blf_status_t               status,
    output logic [blf_pkg::LEVEL_W-1:0]        m_duty,
    output logic                               m_fade_active
);

    localparam int LW = blf_pkg::LEVEL_W;
    localparam int DW = blf_pkg::DUR_W;
    localparam int PW = blf_pkg::PROD_W;

    // Fade state
    logic          running_reg;
    logic [LW-1:0] from_reg;
    logic [LW-1:0] goal_reg;
    logic [DW-1:0] elapsed_reg;
    logic [DW-1:0] length_reg;
    logic [LW-1:0] stored_reg;
    logic [LW-1:0] applied_reg;

    // Interpolation datapath
    logic          up_reg;
    logic [PW-1:0] base_reg;
    logic [PW-1:0] step_reg;
    logic [DW-1:0] rem_reg;
    logic [LW-1:0] dvd_reg;
    logic [LW-1:0] quo_reg;

    // Result register
    logic [LW-1:0] duty_out_reg;
    logic          active_out_reg;

    logic [DW-1:0] elapsed_inc;
    logic [LW-1:0] diff;
    logic [PW-1:0] num;
    logic [DW:0]   trial;
    logic          trial_ge;
    logic          apply_in_range;

    // Saturating tick count and the decision to interpolate
    always_comb begin
        elapsed_inc = (elapsed_reg == {DW{1'b1}}) ? elapsed_reg : elapsed_reg + DW'(1);
        status.need_div = (s_op == blf_pkg::OP_TICK) && running_reg
                          && (elapsed_inc < length_reg);
    end

    // Product operands, sum and division step
    always_comb begin
        diff     = (goal_reg >= from_reg) ? (goal_reg - from_reg) : (from_reg - goal_reg);
        num      = up_reg ? (base_reg + step_reg) : (base_reg - step_reg);
        trial    = {rem_reg, dvd_reg[LW-1]};
        trial_ge = (trial >= {1'b0, length_reg});
    end

    // Fade state update on an accepted item and on the final quotient
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            from_reg    <= '0;
            goal_reg    <= '0;
            elapsed_reg <= '0;
            length_reg  <= '0;
            stored_reg  <= '0;
            applied_reg <= '0;
        end else if (cmd.accept) begin
            unique case (blf_pkg::op_t'(s_op))
                blf_pkg::OP_SET: begin
                    running_reg <= 1'b0;
                    stored_reg  <= s_level;
                    applied_reg <= s_level;
                end
                blf_pkg::OP_FADE: begin
                    if (!(running_reg && (goal_reg == s_level))) begin
                        from_reg    <= stored_reg;
                        goal_reg    <= s_level;
                        elapsed_reg <= '0;
                        length_reg  <= s_duration_ms;
                        running_reg <= 1'b1;
                    end
                end
                blf_pkg::OP_SWITCH: begin
                    running_reg <= 1'b0;
                    applied_reg <= s_backlight_on ? stored_reg : '0;
                end
                blf_pkg::OP_TICK: begin
                    if (running_reg) begin
                        elapsed_reg <= elapsed_inc;
                        if (elapsed_inc >= length_reg) begin
                            applied_reg <= goal_reg;
                            stored_reg  <= goal_reg;
                            running_reg <= 1'b0;
                        end
                    end
                end
                default: begin
                    running_reg <= running_reg;
                end
            endcase
        end else if (cmd.apply) begin
            applied_reg <= quo_reg;
        end
    end

    // Multiply, load divider, restoring division
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            up_reg   <= (goal_reg >= from_reg);
            base_reg <= PW'(from_reg) * PW'(length_reg);
            step_reg <= PW'(elapsed_reg) * PW'(diff);
        end
        if (cmd.sum) begin
            // numerator stays below 256 * length, so the high part fits the remainder
            rem_reg <= num[PW-1:LW];
            dvd_reg <= num[LW-1:0];
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? DW'(trial - {1'b0, length_reg}) : trial[DW-1:0];
            dvd_reg <= {dvd_reg[LW-2:0], 1'b0};
            quo_reg <= {quo_reg[LW-2:0], trial_ge};
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            duty_out_reg   <= applied_reg;
            active_out_reg <= running_reg;
        end
    end

    assign m_duty        = duty_out_reg;
    assign m_fade_active = active_out_reg;

    // Quotient lies between the fade endpoints
    assign apply_in_range = ((quo_reg >= from_reg) && (quo_reg <= goal_reg))
                            || ((quo_reg <= from_reg) && (quo_reg >= goal_reg));

    // Interpolated duty only while a fade runs, and between its endpoints
    `BLF_ASSERT_SAME(a_apply_running, aclk, aresetn, cmd.apply, running_reg)
    `BLF_ASSERT_SAME(a_apply_bounded, aclk, aresetn, cmd.apply, apply_in_range)

endmodule

`default_nettype wire

>>> hdl/blf_ctrl.sv
// ============================================================================
// blf_ctrl
// Sequencer for the fade unit: item intake, interpolation steps, result push.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "backlight_linear_fade_unit_assert.svh"

module blf_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire blf_pkg::blf_status_t  status,
    output blf_pkg::blf_cmd_t          cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_SUM   = 6'b000100,
        S_DIV   = 6'b001000,
        S_APPLY = 6'b010000,
        S_PUSH  = 6'b100000
    } state_t;

    localparam int CW = blf_pkg::DIV_CNT_W;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic          last_step;

    assign last_step = (cnt_reg == CW'(blf_pkg::DIV_STEPS - 1));

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = status.need_div ? S_MUL : S_PUSH;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (last_step) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH: begin
                // wait for the result register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        m_valid_next = cmd.push | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `BLF_ASSERT_SAME(a_push_slot_free, aclk, aresetn, cmd.push, !m_valid_reg || m_ready)
    `BLF_ASSERT_NEXT(a_div_path, aclk, aresetn, cmd.accept && status.need_div, state_reg == S_MUL)
    `BLF_ASSERT_NEXT(a_div_ends, aclk, aresetn, (state_reg == S_DIV) && last_step, state_reg == S_APPLY)
    `BLF_ASSERT_NEXT(a_push_valid, aclk, aresetn, cmd.push, m_valid_reg)

endmodule

`default_nettype wire

>>> hdl/backlight_linear_fade_unit.sv
// ============================================================================
// backlight_linear_fade_unit
// Backlight PWM duty controller with set, linear fade, on/off and ms tick.
// ============================================================================
// Usage:
//   Input channel s_*: one operation per transfer (s_op with s_level,
//   s_duration_ms, s_backlight_on). Result channel m_*: exactly one transfer
//   per input, carrying the applied duty and the fade-active flag.
//   Set, fade start, switch and a tick that does not interpolate go from
//   intake straight to the push into the result register. A tick inside
//   a running fade passes through the multiply state, the add state, the
//   bit-serial restoring divider (one quotient bit per cycle, one step per
//   bit of the level width), the apply state and the push into the result
//   register. Throughput: one item in flight; s_ready is high only when
//   the sequencer is idle, so a new item is taken only after the last push.
//   The result register decouples the two sides: a new input is taken while
//   the previous result still waits; if the receiver stalls longer, the
//   next result holds inside the block and s_ready stays low.
//   Reset (aresetn low, synchronous): fade stopped, brightness and duty 0,
//   no result pending.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module backlight_linear_fade_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [blf_pkg::OP_W-1:0]      s_op,
    input  wire logic [blf_pkg::LEVEL_W-1:0]   s_level,
    input  wire logic [blf_pkg::DUR_W-1:0]     s_duration_ms,
    input  wire logic                          s_backlight_on,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [blf_pkg::LEVEL_W-1:0]        m_duty,
    output logic                               m_fade_active
);

    blf_pkg::blf_cmd_t    cmd;
    blf_pkg::blf_status_t status;

    // Sequencer
    blf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // State, arithmetic and result register
    blf_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_op           (s_op),
        .s_level        (s_level),
        .s_duration_ms  (s_duration_ms),
        .s_backlight_on (s_backlight_on),
        .cmd            (cmd),
        .status         (status),
        .m_duty         (m_duty),
        .m_fade_active  (m_fade_active)
    );

endmodule

`default_nettype wire

>>> verif/backlight_linear_fade_unit_tb.sv
// ============================================================================
// backlight_linear_fade_unit_tb
// Self-checking bench for the backlight fade unit. Directed tests cover set,
// on/off, fades up and down, zero-length fades, repeated requests and a long
// fade. These are followed by random fade sequences with random handshake
// gaps. A shadow of the controller state predicts every result transfer.
// ============================================================================
`timescale 1ns / 1ps

module backlight_linear_fade_unit_tb;

    localparam int OP_W          = blf_pkg::OP_W;
    localparam int LEVEL_W       = blf_pkg::LEVEL_W;
    localparam int DUR_W         = blf_pkg::DUR_W;
    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 6;
    localparam int QUIET_LIMIT   = 5000;  // cycles without any transfer
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int MAX_GAP       = 14;
    localparam int LONG_HOLD     = 160;

    typedef struct packed {
        logic [LEVEL_W-1:0] duty;
        logic               fade_active;
    } blf_result_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op           = '0;
    logic [LEVEL_W-1:0]  s_level        = '0;
    logic [DUR_W-1:0]    s_duration_ms  = '0;
    logic                s_backlight_on = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [LEVEL_W-1:0]  m_duty;
    logic                m_fade_active;

    // Shadow of the controller state
    logic                sh_running    = 1'b0;
    logic [LEVEL_W-1:0]  sh_from       = '0;
    logic [LEVEL_W-1:0]  sh_goal       = '0;
    logic [DUR_W-1:0]    sh_elapsed    = '0;
    logic [DUR_W-1:0]    sh_length     = '0;
    logic [LEVEL_W-1:0]  sh_brightness = '0;
    logic [LEVEL_W-1:0]  sh_duty       = '0;

    blf_result_t         duty_expect_q[$];
    int                  mismatches    = 0;
    int                  tx_max_gap    = MAX_GAP;
    int                  rx_max_stall  = MAX_GAP;
    int                  rx_hold_cycles = 0;

    backlight_linear_fade_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_level        (s_level),
        .s_duration_ms  (s_duration_ms),
        .s_backlight_on (s_backlight_on),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_duty         (m_duty),
        .m_fade_active  (m_fade_active)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Duty prediction: advance the shadow by one accepted operation
    // ------------------------------------------------------------------------
    task automatic step_fade_shadow(input blf_pkg::op_t op, input logic [LEVEL_W-1:0] level,
                                    input logic [DUR_W-1:0] dur, input logic on);
        logic [31:0] numer;
        blf_result_t res;
        case (op)
            blf_pkg::OP_SET: begin
                sh_running    = 1'b0;
                sh_brightness = level;
                sh_duty       = level;
            end
            blf_pkg::OP_FADE: begin
                // a request toward the goal already being faded to is dropped
                if (!(sh_running && sh_goal == level)) begin
                    sh_from    = sh_brightness;
                    sh_goal    = level;
                    sh_elapsed = '0;
                    sh_length  = dur;
                    sh_running = 1'b1;
                end
            end
            blf_pkg::OP_SWITCH: begin
                sh_running = 1'b0;
                sh_duty    = on ? sh_brightness : '0;
            end
            blf_pkg::OP_TICK: begin
                if (sh_running) begin
                    if (sh_elapsed != 16'hFFFF)
                        sh_elapsed = sh_elapsed + 1'b1;
                    if (sh_elapsed >= sh_length) begin
                        sh_duty       = sh_goal;
                        sh_brightness = sh_goal;
                        sh_running    = 1'b0;
                    end else begin
                        // exact line from start to goal, floored
                        if (sh_goal >= sh_from)
                            numer = 32'(sh_from) * 32'(sh_length)
                                  + 32'(sh_elapsed) * (32'(sh_goal) - 32'(sh_from));
                        else
                            numer = 32'(sh_from) * 32'(sh_length)
                                  - 32'(sh_elapsed) * (32'(sh_from) - 32'(sh_goal));
                        sh_duty = 8'(numer / 32'(sh_length));
                    end
                end
            end
            default: ;
        endcase
        res.duty        = sh_duty;
        res.fade_active = sh_running;
        duty_expect_q.push_back(res);
    endtask

    // Input transfers drive the shadow
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            step_fade_shadow(blf_pkg::op_t'(s_op), s_level, s_duration_ms, s_backlight_on);
    end

    // ------------------------------------------------------------------------
    // Result check against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_result
        blf_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (duty_expect_q.size() == 0) begin
                $error("unexpected result transfer: duty %0d fade_active %0b",
                       m_duty, m_fade_active);
                mismatches++;
            end else begin
                want = duty_expect_q.pop_front();
                if (m_duty !== want.duty) begin
                    $error("duty: expected %0d, got %0d", want.duty, m_duty);
                    mismatches++;
                end
                if (m_fade_active !== want.fade_active) begin
                    $error("fade_active: expected %0b, got %0b",
                           want.fade_active, m_fade_active);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stall per transfer, long hold on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = (rx_max_stall == 0) ? 0 : $urandom_range(rx_max_stall, 0);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer ends the run
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender: random gap, then hold the operation until its transfer
    // ------------------------------------------------------------------------
    task automatic send_op(input blf_pkg::op_t op, input logic [LEVEL_W-1:0] level,
                           input logic [DUR_W-1:0] dur, input logic on);
        int gap;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(tx_max_gap, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_level        <= level;
        s_duration_ms  <= dur;
        s_backlight_on <= on;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Sender pauses until every predicted result has come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        // let the shadow record the last transfer first
        @(posedge aclk);
        while (duty_expect_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_set_and_switch();
        send_op(blf_pkg::OP_SET, 8'hFF, 16'hFFFF, 1'b1);
        send_op(blf_pkg::OP_SET, 8'hA5, 16'h0000, 1'b0);
        send_op(blf_pkg::OP_SWITCH, 8'h00, 16'h0000, 1'b0);   // off keeps brightness
        send_op(blf_pkg::OP_TICK, 8'h5A, 16'h1234, 1'b1);     // tick with no fade
        send_op(blf_pkg::OP_SWITCH, 8'hFF, 16'hFFFF, 1'b1);   // back on at brightness
        wait_results_drained();
    endtask

    task automatic test_fade_up_down();
        send_op(blf_pkg::OP_FADE, 8'd250, 16'd4, 1'b0);
        repeat (4) send_op(blf_pkg::OP_TICK, 8'd0, 16'd0, 1'b0);
        send_op(blf_pkg::OP_FADE, 8'd0, 16'd3, 1'b1);
        repeat (3) send_op(blf_pkg::OP_TICK, 8'd0, 16'd0, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_zero_length_and_repeat();
        // zero-length fade completes on the first tick
        send_op(blf_pkg::OP_FADE, 8'd77, 16'd0, 1'b0);
        send_op(blf_pkg::OP_TICK, 8'd0, 16'd0, 1'b0);
        // repeated request to the same goal is dropped, a new goal restarts
        send_op(blf_pkg::OP_FADE, 8'd200, 16'd4, 1'b0);
        send_op(blf_pkg::OP_TICK, 8'd0, 16'd0, 1'b0);
        send_op(blf_pkg::OP_FADE, 8'd200, 16'd1, 1'b0);
        send_op(blf_pkg::OP_TICK, 8'd0, 16'd0, 1'b0);
        send_op(blf_pkg::OP_FADE, 8'd10, 16'd2, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_long_fade_from_stored();
        // fade starts at the stored brightness even while switched off
        send_op(blf_pkg::OP_SWITCH, 8'd0, 16'd0, 1'b0);
        send_op(blf_pkg::OP_FADE, 8'd255, 16'hFFFF, 1'b0);
        send_op(blf_pkg::OP_TICK, 8'd0, 16'd0, 1'b0);
        send_op(blf_pkg::OP_TICK, 8'd0, 16'd0, 1'b0);
        send_op(blf_pkg::OP_SET, 8'd0, 16'd0, 1'b0);          // set cancels the fade
        wait_results_drained();
    endtask

    // Receiver holds off while the sender keeps offering back to back
    task automatic test_result_backpressure();
        tx_max_gap     = 0;
        rx_hold_cycles = LONG_HOLD;
        send_op(blf_pkg::OP_SET, 8'd3, 16'd0, 1'b0);
        send_op(blf_pkg::OP_FADE, 8'd180, 16'd9, 1'b0);
        repeat (10) send_op(blf_pkg::OP_TICK, LEVEL_W'($urandom), DUR_W'($urandom),
                            1'($urandom));
        tx_max_gap = MAX_GAP;
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // Random fade sequences with interleaved noise
    // ------------------------------------------------------------------------
    task automatic test_random_fades();
        int sent;
        int ticks;
        logic [DUR_W-1:0]   len;
        logic [LEVEL_W-1:0] goal;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // every fifth stretch runs without idling on either side
            if ((sent / 150) % 5 == 4) begin
                tx_max_gap   = 0;
                rx_max_stall = 0;
            end else begin
                tx_max_gap   = MAX_GAP;
                rx_max_stall = MAX_GAP;
            end
            if ($urandom_range(9, 0) < 8) begin
                if ($urandom_range(3, 0) == 0) begin
                    send_op(blf_pkg::OP_SET, LEVEL_W'($urandom), DUR_W'($urandom),
                            1'($urandom));
                    sent++;
                end
                goal = LEVEL_W'($urandom);
                case ($urandom_range(9, 0))
                    0:       len = '0;
                    1:       len = DUR_W'($urandom);
                    default: len = DUR_W'($urandom_range(24, 1));
                endcase
                send_op(blf_pkg::OP_FADE, goal, len, 1'($urandom));
                sent++;
                ticks = (len > 40) ? $urandom_range(30, 1) : len + $urandom_range(2, 0);
                repeat (ticks) begin
                    case ($urandom_range(29, 0))
                        0:       send_op(blf_pkg::OP_FADE, goal, DUR_W'($urandom),
                                         1'($urandom));
                        1:       send_op(blf_pkg::OP_FADE, LEVEL_W'($urandom),
                                         DUR_W'($urandom_range(16, 0)), 1'($urandom));
                        2:       send_op(blf_pkg::OP_SWITCH, LEVEL_W'($urandom),
                                         DUR_W'($urandom), 1'($urandom));
                        3:       send_op(blf_pkg::OP_SET, LEVEL_W'($urandom),
                                         DUR_W'($urandom), 1'($urandom));
                        default: send_op(blf_pkg::OP_TICK, LEVEL_W'($urandom),
                                         DUR_W'($urandom), 1'($urandom));
                    endcase
                    sent++;
                end
            end else begin
                send_op(blf_pkg::op_t'($urandom_range(3, 0)), LEVEL_W'($urandom),
                        DUR_W'($urandom), 1'($urandom));
                sent++;
            end
        end
        tx_max_gap   = MAX_GAP;
        rx_max_stall = MAX_GAP;
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_set_and_switch();
        test_fade_up_down();
        test_zero_length_and_repeat();
        test_long_fade_from_stored();
        test_result_backpressure();
        test_random_fades();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && duty_expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
